FILE: rtl/assert_macros.svh
// assertion macros used by the checker file cgi_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");
`endif

FILE: rtl/cgi_pkg.sv
// types and constants of the colour gradient interpolator
// no dependencies
`default_nettype none
package cgi_pkg;
   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_PERCENT = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_INDEX   = 3'd4;
   localparam logic [6:0] PCT_MAX    = 7'd100;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] stop_percent;
      logic [7:0] stop_red;
      logic [7:0] stop_green;
      logic [7:0] stop_blue;
      logic [9:0] step_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  position;
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
   } rsp_type;

   // queue entry: the beat plus a range check done at the front
   typedef struct packed {
      req_type    req;
      logic       pct_bad;
   } cmd_type;
endpackage
`default_nettype wire

FILE: rtl/cgi_div.sv
// serial restoring divider, one quotient bit a cycle
// depends on nothing
`default_nettype none
module cgi_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] num,
   input  wire logic [15:0] den,
   output logic             done,
   output logic [31:0]      quot
);
   logic [31:0] q_ff, q_in;
   logic [16:0] r_ff, r_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [16:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; run_in = run_ff;
      trial = {r_ff[15:0], q_ff[31]};
      if (start) begin
         q_in = num; r_in = '0; cnt_in = 6'd32; run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den}) begin
            r_in = trial - {1'b0, den};
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; cnt_ff <= cnt_in;
      if (reset) run_ff <= 1'b0;
      else run_ff <= run_in;
   end
   assign done = run_ff && (cnt_ff == 6'd1);
   assign quot = q_in;
endmodule
`default_nettype wire

FILE: rtl/cgi_front.sv
// front: accepts beats, checks percent range, feeds a short queue
// depends on cgi_pkg
`default_nettype none
module cgi_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire cgi_pkg::req_type  req_data,
   output logic                   busy,
   input  wire logic              pop,
   output logic                   cmd_valid,
   output cgi_pkg::cmd_type       cmd
);
   import cgi_pkg::*;
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff;
   logic       wp_ff, rp_ff;
   logic       push;

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rp_ff];

   // two-entry queue
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff].req <= req_data;
         q_ff[wp_ff].pct_bad <= (req_data.stop_percent > PCT_MAX);
      end
      if (reset) begin
         cnt_ff <= '0; wp_ff <= 1'b0; rp_ff <= 1'b0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

FILE: rtl/cgi_back.sv
// back: stop table sequencer, search and serial divisions
// depends on cgi_pkg and cgi_div
`default_nettype none
module cgi_back #(
   parameter int MAX_STOPS = 16,
   parameter int MAX_STEPS = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [10:0]       step_count,
   input  wire logic              cmd_valid,
   input  wire cgi_pkg::cmd_type  cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   output cgi_pkg::rsp_type       rsp_data
);
   import cgi_pkg::*;
   localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int CW = $clog2(MAX_STOPS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_SHIFT = 4'd2;
   localparam logic [3:0] S_WRITE = 4'd3;
   localparam logic [3:0] S_TDIV  = 4'd4;
   localparam logic [3:0] S_QSCAN = 4'd5;
   localparam logic [3:0] S_QRD   = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_CDIV  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;
   localparam logic [3:0] S_RDW   = 4'd10;

   // table memory: percent and colour
   logic [30:0] mem [MAX_STOPS];
   logic [30:0] rd_ff;
   logic [IW-1:0] ra, wa;
   logic          we;
   logic [30:0]   wd;
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   logic [3:0]    st_ff, st_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] k_ff, k_in;
   cmd_type       c_ff, c_in;
   logic [6:0]    t_ff, t_in;
   logic [30:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [1:0]    ch_ff, ch_in;
   logic [15:0]   acc_ff [3];
   logic [15:0]   acc_in [3];
   logic [31:0]   num_ff, num_in;
   logic          ds;
   logic [31:0]   dn;
   logic [15:0]   dd;
   logic          ddone;
   logic [31:0]   dq;
   logic [2:0]    stat_in;
   logic          rv_in;
   logic          bad_cfg;

   cgi_div u_div (.clock(clock), .reset(reset), .start(ds), .num(dn), .den(dd),
      .done(ddone), .quot(dq));

   assign bad_cfg = (step_count < 11'd2) || ({21'd0, step_count} > MAX_STEPS)
      || ({1'b0, c_ff.req.step_index} >= step_count);

   logic [7:0] ca, cb, ma, mb;
   logic [6:0] dpct;
   always_comb begin
      ca = lo_ff[8*(2-ch_ff) +: 8];
      cb = hi_ff[8*(2-ch_ff) +: 8];
      ma = {1'b0, hi_ff[30:24]} - {1'b0, t_ff};
      mb = {1'b0, t_ff} - {1'b0, lo_ff[30:24]};
      dpct = hi_ff[30:24] - lo_ff[30:24];
   end

   // sequencer
   always_comb begin
      st_in = st_ff; n_in = n_ff; k_in = k_ff; c_in = c_ff; t_in = t_ff;
      lo_in = lo_ff; hi_in = hi_ff; ch_in = ch_ff; num_in = num_ff;
      for (int i = 0; i < 3; i++) acc_in[i] = acc_ff[i];
      pop = 1'b0; ra = k_ff[IW-1:0]; wa = k_ff[IW-1:0]; we = 1'b0;
      wd = {c_ff.req.stop_percent, c_ff.req.stop_red, c_ff.req.stop_green,
            c_ff.req.stop_blue};
      ds = 1'b0; dn = '0; dd = 16'd1; rv_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               pop = 1'b1; c_in = cmd; k_in = '0; ch_in = '0;
               for (int i = 0; i < 3; i++) acc_in[i] = '0;
               t_in = '0;
               case (cmd.req.kind)
                  KIND_CLEAR: begin n_in = '0; st_in = S_DONE; end
                  KIND_LOAD: st_in = cmd.pct_bad ? S_DONE : S_RDW;
                  KIND_QUERY: st_in = S_DONE;
                  default: st_in = S_DONE;
               endcase
               if (cmd.req.kind == KIND_QUERY && n_ff != '0) st_in = S_TDIV;
            end
         end
         // wait for read of entry k
         S_RDW: begin
            if (k_ff == n_ff) st_in = (n_ff == CW'(MAX_STOPS)) ? S_DONE : S_WRITE;
            else st_in = S_SCAN;
         end
         S_SCAN: begin
            if (rd_ff[30:24] == c_ff.req.stop_percent) begin
               we = 1'b1; st_in = S_DONE;
            end else if (rd_ff[30:24] > c_ff.req.stop_percent) begin
               st_in = (n_ff == CW'(MAX_STOPS)) ? S_DONE : S_SHIFT;
               k_in = n_ff;
            end else begin
               k_in = k_ff + 1'b1; st_in = S_RDW; ra = k_in[IW-1:0];
            end
            if (rd_ff[30:24] != c_ff.req.stop_percent
                && rd_ff[30:24] <= c_ff.req.stop_percent) ra = k_in[IW-1:0];
         end
         // move entries up by one until the insert slot, then write
         S_SHIFT: begin
            ra = k_ff[IW-1:0] - 1'b1;
            st_in = S_QRD;
            ch_in = 2'd3;
         end
         S_WRITE: begin
            we = 1'b1; n_in = n_ff + 1'b1; st_in = S_DONE;
         end
         S_TDIV: begin
            if (bad_cfg) st_in = S_DONE;
            else begin
               ds = (ch_ff != 2'd1);
               dn = 32'(c_ff.req.step_index) * 32'd100;
               dd = 16'(step_count - 11'd1);
               ch_in = 2'd1;
               if (ddone) begin
                  t_in = dq[6:0]; k_in = '0; ra = '0; st_in = S_QSCAN; ch_in = 2'd0;
               end
            end
         end
         S_QSCAN: begin
            ra = k_ff[IW-1:0]; st_in = S_QRD; ch_in = 2'd2;
         end
         S_QRD: begin
            if (ch_ff == 2'd3) begin
               // shift step: entry k-1 read, store at k
               wa = k_ff[IW-1:0];
               if (rd_ff[30:24] > c_ff.req.stop_percent) begin
                  we = 1'b1; wd = rd_ff; k_in = k_ff - 1'b1;
                  st_in = (k_ff == CW'(1)) ? S_WRITE : S_SHIFT;
                  if (k_ff == CW'(1)) k_in = '0;
               end else st_in = S_WRITE;
            end else begin
               // search: first stop with pct >= t, padded ends
               if (k_ff == '0) begin
                  lo_in = {7'd0, rd_ff[23:0]};
               end
               if (rd_ff[30:24] >= t_ff) begin
                  hi_in = rd_ff;
                  if (k_ff != '0) st_in = S_MUL;
                  else if (rd_ff[30:24] == 7'd0) begin
                     // only t=0 reaches the first stop at zero
                     lo_in = {7'd0, rd_ff[23:0]}; hi_in = {PCT_MAX, rd_ff[23:0]};
                     st_in = S_MUL;
                  end else st_in = S_MUL;
               end else if (k_ff + 1'b1 == n_ff) begin
                  lo_in = rd_ff; hi_in = {PCT_MAX, rd_ff[23:0]}; st_in = S_MUL;
               end else begin
                  lo_in = rd_ff; k_in = k_ff + 1'b1; st_in = S_QSCAN;
               end
               ch_in = 2'd0;
            end
         end
         S_MUL: begin
            num_in = 32'((16'(ca) * 16'(ma) + 16'(cb) * 16'(mb))) << 8;
            st_in = S_CDIV;
         end
         S_CDIV: begin
            ds = (k_ff != CW'(MAX_STOPS)) && !ddone;
            dn = num_ff; dd = {9'd0, dpct};
            if (dpct == 7'd0) begin
               acc_in[ch_ff] = '0; ds = 1'b0;
               ch_in = ch_ff + 1'b1; st_in = (ch_ff == 2'd2) ? S_DONE : S_MUL;
            end else begin
               if (!ddone) begin
                  k_in = CW'(MAX_STOPS);
                  if (k_ff == CW'(MAX_STOPS)) ds = 1'b0;
               end else begin
                  acc_in[ch_ff] = dq[15:0]; k_in = '0;
                  ch_in = ch_ff + 1'b1; st_in = (ch_ff == 2'd2) ? S_DONE : S_MUL;
               end
            end
         end
         S_DONE: begin
            rv_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // result register and status
   always_comb begin
      if (c_ff.req.kind == KIND_LOAD)
         stat_in = c_ff.pct_bad ? ST_PERCENT :
                   (n_ff == CW'(MAX_STOPS) && !we && st_ff != S_WRITE) ? ST_FULL : ST_OK;
      else if (c_ff.req.kind == KIND_QUERY)
         stat_in = (n_ff == '0) ? ST_EMPTY : bad_cfg ? ST_INDEX : ST_OK;
      else stat_in = ST_OK;
   end

   logic       fl_ff;
   always_ff @(posedge clock) begin
      st_ff <= reset ? S_IDLE : st_in;
      n_ff <= reset ? '0 : n_in;
      rsp_valid <= reset ? 1'b0 : rv_in;
      if (st_ff == S_IDLE) fl_ff <= 1'b0;
      else if (we || st_ff == S_WRITE) fl_ff <= 1'b1;
      k_ff <= k_in; c_ff <= c_in; t_ff <= t_in; lo_ff <= lo_in; hi_ff <= hi_in;
      ch_ff <= ch_in; num_ff <= num_in;
      for (int i = 0; i < 3; i++) acc_ff[i] <= acc_in[i];
      if (st_ff == S_DONE) begin
         rsp_data.status <= (c_ff.req.kind == KIND_LOAD && !c_ff.pct_bad)
            ? (fl_ff ? ST_OK : ST_FULL) : stat_in;
         if (c_ff.req.kind == KIND_QUERY && stat_in == ST_OK) begin
            rsp_data.position <= t_ff;
            rsp_data.red_out <= acc_ff[0];
            rsp_data.green_out <= acc_ff[1];
            rsp_data.blue_out <= acc_ff[2];
         end else begin
            rsp_data.position <= '0; rsp_data.red_out <= '0;
            rsp_data.green_out <= '0; rsp_data.blue_out <= '0;
         end
      end
   end
endmodule
`default_nettype wire

FILE: rtl/color_gradient_interpolator.sv
// top level of the colour gradient interpolator
// depends on cgi_pkg, cgi_front, cgi_back
// channel   | ports              | flow
// request   | start busy req_data| in, held off by busy
// response  | rsp_valid rsp_data | out, one cycle, no stall
// csr       | csr_we csr_wdata   | write only
// a clear or an unused kind goes straight to its result; a load scans the stops
// and moves the larger ones up before its write; a query divides once for t,
// scans the stops, then multiplies and divides for each colour channel,
// all divisions on the one serial divider.
// busy rises when the two-entry queue is full; the receiver cannot stall.
// reset clears the stop count and the queue; the table is left as is.
`default_nettype none
module color_gradient_interpolator #(
   parameter int MAX_STOPS = 16,
   parameter int MAX_STEPS = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire cgi_pkg::req_type req_data,
   output logic                  rsp_valid,
   output cgi_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [10:0]      csr_wdata
);
   import cgi_pkg::*;
   logic [10:0] steps_ff;
   logic        pop, cv;
   cmd_type     cmd;

   // step count register
   always_ff @(posedge clock) begin
      if (reset) steps_ff <= 11'd256;
      else if (csr_we) steps_ff <= csr_wdata;
   end

   cgi_front u_front (.clock(clock), .reset(reset), .start(start),
      .req_data(req_data), .busy(busy), .pop(pop), .cmd_valid(cv), .cmd(cmd));
   cgi_back #(.MAX_STOPS(MAX_STOPS), .MAX_STEPS(MAX_STEPS)) u_back (
      .clock(clock), .reset(reset), .step_count(steps_ff), .cmd_valid(cv),
      .cmd(cmd), .pop(pop), .rsp_valid(rsp_valid), .rsp_data(rsp_data));
endmodule
`default_nettype wire

FILE: rtl/cgi_checker.sv
// port-level checks of the colour gradient interpolator
// depends on cgi_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module cgi_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire cgi_pkg::rsp_type rsp_data
);
   import cgi_pkg::*;
   logic fail_beat;
   logic no_colour;

   // failed result beat and an all-zero payload
   assign fail_beat = rsp_valid && (rsp_data.status != ST_OK);
   assign no_colour = (rsp_data.position == 7'd0) && (rsp_data.red_out == 16'd0)
      && (rsp_data.green_out == 16'd0) && (rsp_data.blue_out == 16'd0);

   // status codes stay in range
   `CHK_IMPL(a_status, clock, reset, rsp_valid, rsp_data.status <= ST_INDEX)
   // failed result carries no colour
   `CHK_IMPL(a_zero, clock, reset, fail_beat, no_colour)
   // position never beyond full scale
   `CHK_IMPL(a_pos, clock, reset, rsp_valid, rsp_data.position <= PCT_MAX)
   // strobe lasts one cycle
   `CHK_NEXT(a_pulse, clock, reset, rsp_valid, !rsp_valid)
endmodule
bind color_gradient_interpolator cgi_checker u_chk (.clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data));
`default_nettype wire

FILE: sim/tb_color_gradient_interpolator.sv
// testbench of the colour gradient interpolator: directed and random beats
// checked against an in-bench gradient predictor; depends on cgi_pkg and the rtl
`default_nettype none
module tb_color_gradient_interpolator;
   timeunit 1ns;
   timeprecision 1ps;
   import cgi_pkg::*;

   localparam int N_STOPS = 16;
   localparam int N_STEPS = 1024;
   localparam int LIMIT_CYCLES = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;

   // predictor state
   logic [6:0] grad_pct [N_STOPS];
   logic [7:0] grad_ch [N_STOPS][3];
   int grad_count;
   int steps_cfg;

   rsp_type colour_queue[$];
   int mismatches = 0;
   int cycle_count = 0;
   bit idle_en = 1'b1;

   color_gradient_interpolator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic rsp_type gradient_predict(req_type r);
      rsp_type o;
      int p, k, pos, t, j, n, a, b, d, num;
      int pp [N_STOPS+2];
      int pc [N_STOPS+2][3];
      bit found;
      o = '0;
      o.status = ST_OK;
      if (r.kind == KIND_CLEAR) begin
         grad_count = 0;
      end else if (r.kind == KIND_LOAD) begin
         p = int'(r.stop_percent);
         found = 1'b0;
         if (p > 100) begin
            o.status = ST_PERCENT;
         end else begin
            for (k = 0; k < grad_count; k++)
               if (!found && grad_pct[k] == p) begin
                  grad_ch[k][0] = r.stop_red;
                  grad_ch[k][1] = r.stop_green;
                  grad_ch[k][2] = r.stop_blue;
                  found = 1'b1;
               end
            if (!found) begin
               if (grad_count >= N_STOPS) begin
                  o.status = ST_FULL;
               end else begin
                  pos = 0;
                  while (pos < grad_count && grad_pct[pos] < p) pos++;
                  for (k = grad_count; k > pos; k--) begin
                     grad_pct[k] = grad_pct[k-1];
                     grad_ch[k] = grad_ch[k-1];
                  end
                  grad_pct[pos] = 7'(p);
                  grad_ch[pos][0] = r.stop_red;
                  grad_ch[pos][1] = r.stop_green;
                  grad_ch[pos][2] = r.stop_blue;
                  grad_count++;
               end
            end
         end
      end else if (r.kind == KIND_QUERY) begin
         if (grad_count == 0) begin
            o.status = ST_EMPTY;
         end else if (steps_cfg < 2 || steps_cfg > N_STEPS || r.step_index >= steps_cfg) begin
            o.status = ST_INDEX;
         end else begin
            t = (int'(r.step_index) * 100) / (steps_cfg - 1);
            n = 0;
            // pad with held end colours at 0 and 100
            if (grad_pct[0] != 0) begin
               pp[n] = 0;
               for (k = 0; k < 3; k++) pc[n][k] = int'(grad_ch[0][k]);
               n++;
            end
            for (j = 0; j < grad_count; j++) begin
               pp[n] = int'(grad_pct[j]);
               for (k = 0; k < 3; k++) pc[n][k] = int'(grad_ch[j][k]);
               n++;
            end
            if (grad_pct[grad_count-1] != 100) begin
               pp[n] = 100;
               for (k = 0; k < 3; k++) pc[n][k] = int'(grad_ch[grad_count-1][k]);
               n++;
            end
            j = 1;
            while (j + 1 < n && pp[j] < t) j++;
            a = pp[j] - t;
            b = t - pp[j-1];
            d = pp[j] - pp[j-1];
            o.position = t[6:0];
            for (k = 0; k < 3; k++) begin
               num = (pc[j-1][k] * a + pc[j][k] * b) * 256;
               num = (d != 0) ? num / d : 0;
               if (k == 0) o.red_out = num[15:0];
               else if (k == 1) o.green_out = num[15:0];
               else o.blue_out = num[15:0];
            end
         end
      end
      return o;
   endfunction

   task automatic idle_gap();
      int n;
      if (idle_en && $urandom_range(3) == 0) begin
         n = $urandom_range(9, 1);
         repeat (n) @(negedge clock);
      end
   endtask

   // send one beat, predicting at acceptance
   task automatic send_beat(req_type r);
      idle_gap();
      @(negedge clock);
      req_data <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      colour_queue.push_back(gradient_predict(r));
      @(negedge clock);
      start <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (colour_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            e = colour_queue.pop_front();
            if (e !== rsp_data) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp st=%0d t=%0d r=%h g=%h b=%h act st=%0d t=%0d r=%h g=%h b=%h",
                     e.status, e.position, e.red_out, e.green_out, e.blue_out,
                     rsp_data.status, rsp_data.position, rsp_data.red_out,
                     rsp_data.green_out, rsp_data.blue_out);
            end
         end
      end
   end

   task automatic drain();
      while (colour_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_steps(int v);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v[10:0];
      @(negedge clock);
      csr_we <= 1'b0;
      steps_cfg = v;
   endtask

   function automatic req_type mk(logic [1:0] kd, int p, int rr, int g, int b, int idx);
      req_type r;
      r.kind = kd;
      r.stop_percent = p[6:0];
      r.stop_red = rr[7:0];
      r.stop_green = g[7:0];
      r.stop_blue = b[7:0];
      r.step_index = idx[9:0];
      return r;
   endfunction

   function automatic req_type rand_beat();
      logic [63:0] bits;
      req_type r;
      bits = {$urandom, $urandom};
      r = bits[$bits(req_type)-1:0];
      return r;
   endfunction

   task automatic test_directed();
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 0));          // empty table
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 1023));       // empty and bad index
      send_beat(mk(KIND_LOAD, 127, 255, 255, 255, 0));   // percent too high
      send_beat(mk(KIND_LOAD, 101, 1, 2, 3, 0));
      send_beat(mk(KIND_LOAD, 50, 255, 0, 128, 0));
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 0));          // held below first stop
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 255));        // held above last stop
      send_beat(mk(KIND_LOAD, 0, 0, 255, 0, 0));
      send_beat(mk(KIND_LOAD, 100, 255, 255, 255, 0));
      send_beat(mk(KIND_LOAD, 50, 10, 20, 30, 0));       // replace
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 100));
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 256));        // bad index
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 1023));
      send_beat(mk(KIND_SPARE, 127, 255, 255, 255, 1023)); // unused kind
      send_beat(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 3));
   endtask

   task automatic test_full_table();
      int k;
      send_beat(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
      for (k = 0; k < 17; k++)
         send_beat(mk(KIND_LOAD, k * 6, $urandom, $urandom, $urandom, 0));
      send_beat(mk(KIND_LOAD, 12, 1, 1, 1, 0));          // replace while full
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, $urandom_range(255)));
   endtask

   task automatic test_steps_extremes();
      write_steps(2);
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 0));
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 1));
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 2));
      write_steps(1024);
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 1023));
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 511));
      write_steps(0);
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 0));
      write_steps(2047);
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 0));
      write_steps(1);
      send_beat(mk(KIND_QUERY, 0, 0, 0, 0, 0));
   endtask

   // mostly well-formed gradients: a clear, a few loads, then queries
   task automatic test_random(int items, int steps);
      int sent, k, nl;
      req_type r;
      write_steps(steps);
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(9) == 0) begin
            send_beat(rand_beat());
            sent++;
         end else begin
            send_beat(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
            nl = $urandom_range(18, 1);
            for (k = 0; k < nl; k++) begin
               r = mk(KIND_LOAD, $urandom_range(3) == 0 ? $urandom_range(127)
                      : $urandom_range(100), $urandom, $urandom, $urandom, $urandom);
               send_beat(r);
            end
            for (k = 0; k < 6; k++)
               send_beat(mk(KIND_QUERY, $urandom, $urandom, $urandom, $urandom,
                            $urandom_range(7) == 0 ? $urandom : $urandom_range(steps - 1)));
            sent += nl + 7;
         end
      end
   endtask

   initial begin
      steps_cfg = 256;
      grad_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_steps_extremes();
      test_random(110, 2 + $urandom_range(30));
      drain();                                            // sender waits for all results
      test_random(110, 1024);
      idle_en = 1'b0;
      test_random(110, $urandom_range(1024, 2));
      drain();
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/cgi_pkg.sv
rtl/cgi_div.sv
rtl/cgi_front.sv
rtl/cgi_back.sv
rtl/color_gradient_interpolator.sv
rtl/cgi_checker.sv
sim/tb_color_gradient_interpolator.sv
